// ----- src/pgf_pkg.sv -----
// Package with shared widths, types and codes of the pairwise gravity force pipeline.
`timescale 1ns / 1ps
package pgf_pkg;

    localparam int POS_W  = 32;
    localparam int AD_W   = 33;
    localparam int C_W    = 34;
    localparam int C2_W   = 68;
    localparam int S_W    = 66;
    localparam int P_W    = 96;
    localparam int FNUM_W = 104;
    localparam int ROOT_W = 34;
    localparam int RAD_W  = 2 * ROOT_W;
    localparam int REM_W  = ROOT_W + 2;
    localparam int FMAG_W = 47;
    localparam int PROD_W = FMAG_W + AD_W;
    localparam int OUT_W  = 48;
    localparam int SPLIT  = 24;

    typedef enum logic [1:0] {
        KIND_PLAIN    = 2'd0,
        KIND_AST_STAR = 2'd1,
        KIND_STAR_AST = 2'd2
    } kind_t;

    // Per-pair geometry and flags that ride along the pipeline.
    typedef struct packed {
        logic                      enable;
        logic                      collided;
        logic [2:0]                neg;
        logic [2:0][AD_W-1:0]      ad;
    } geo_t;

    localparam int GEO_W = $bits(geo_t);

endpackage

// ----- src/pgf_front.sv -----
// Front end: difference vector, contact distance, squared length, mass product and collision test.
`timescale 1ns / 1ps
module pgf_front import pgf_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [POS_W-1:0]   self_pos_x,
    input  logic [POS_W-1:0]   self_pos_y,
    input  logic [POS_W-1:0]   self_pos_z,
    input  logic [POS_W-1:0]   other_pos_x,
    input  logic [POS_W-1:0]   other_pos_y,
    input  logic [POS_W-1:0]   other_pos_z,
    input  logic [31:0]        self_mass,
    input  logic [31:0]        other_mass,
    input  logic [31:0]        self_radius,
    input  logic [31:0]        other_radius,
    input  logic [1:0]         pair_kind,
    input  logic               enable,
    input  logic [31:0]        grav_const,
    output logic               out_valid,
    output logic [S_W-1:0]     out_s,
    output logic [P_W-1:0]     out_p,
    output geo_t               out_geo
);

    logic [2:0][AD_W-1:0] d_a;
    logic [2:0][AD_W-1:0] ad_a;
    logic [C_W-1:0]       contact_a;

    logic                 a_valid_reg;
    logic                 a_en_reg;
    logic [2:0]           a_neg_reg;
    logic [2:0][AD_W-1:0] a_ad_reg;
    logic [C_W-1:0]       a_contact_reg;
    logic [63:0]          a_mm_reg;

    logic                 b_valid_reg;
    logic                 b_en_reg;
    logic [2:0]           b_neg_reg;
    logic [2:0][AD_W-1:0] b_ad_reg;
    logic [2:0][S_W-1:0]  b_sq_reg;
    logic [C2_W-1:0]      b_c2_reg;
    logic [63:0]          b_pl_reg;
    logic [63:0]          b_ph_reg;

    logic [S_W-1:0]       s_next;
    logic                 c_valid_reg;
    logic [S_W-1:0]       c_s_reg;
    logic [P_W-1:0]       c_p_reg;
    geo_t                 c_geo_reg;

    always_comb
    begin
        d_a[0] = {other_pos_x[POS_W-1], other_pos_x} - {self_pos_x[POS_W-1], self_pos_x};
        d_a[1] = {other_pos_y[POS_W-1], other_pos_y} - {self_pos_y[POS_W-1], self_pos_y};
        d_a[2] = {other_pos_z[POS_W-1], other_pos_z} - {self_pos_z[POS_W-1], self_pos_z};
        for (int i = 0; i < 3; i++)
        begin
            ad_a[i] = d_a[i][AD_W-1] ? (~d_a[i] + AD_W'(1)) : d_a[i];
        end
        case (pair_kind)
            KIND_AST_STAR: contact_a = {2'b00, self_radius} + {1'b0, other_radius, 1'b0};
            KIND_STAR_AST: contact_a = {2'b00, other_radius} + {1'b0, self_radius, 1'b0};
            default:       contact_a = {2'b00, self_radius} + {2'b00, other_radius};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    assign s_next = b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_en_reg      <= enable;
            a_neg_reg     <= {d_a[2][AD_W-1], d_a[1][AD_W-1], d_a[0][AD_W-1]};
            a_ad_reg      <= ad_a;
            a_contact_reg <= contact_a;
            a_mm_reg      <= 64'(self_mass) * 64'(other_mass);

            b_en_reg  <= a_en_reg;
            b_neg_reg <= a_neg_reg;
            b_ad_reg  <= a_ad_reg;
            for (int i = 0; i < 3; i++)
            begin
                b_sq_reg[i] <= S_W'(a_ad_reg[i]) * S_W'(a_ad_reg[i]);
            end
            b_c2_reg <= C2_W'(a_contact_reg) * C2_W'(a_contact_reg);
            b_pl_reg <= 64'(grav_const) * 64'(a_mm_reg[31:0]);
            b_ph_reg <= 64'(grav_const) * 64'(a_mm_reg[63:32]);

            c_s_reg            <= s_next;
            c_p_reg            <= {b_ph_reg, 32'd0} + {32'd0, b_pl_reg};
            c_geo_reg.enable   <= b_en_reg;
            c_geo_reg.collided <= b_en_reg && ({2'b00, s_next} <= b_c2_reg);
            c_geo_reg.neg      <= b_neg_reg;
            c_geo_reg.ad       <= b_ad_reg;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_s     = c_s_reg;
    assign out_p     = c_p_reg;
    assign out_geo   = c_geo_reg;

endmodule

// ----- src/pgf_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module pgf_sqrt import pgf_pkg::*; #(
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [S_W-1:0]    in_rad,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0] out_side
);

    logic              v_reg    [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_step
        logic              v_c;
        logic [REM_W-1:0]  rem_c;
        logic [ROOT_W-1:0] root_c;
        logic [RAD_W-1:0]  rad_c;
        logic [SIDE_W-1:0] side_c;
        logic [REM_W+1:0]  cur;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign v_c    = in_valid;
            assign rem_c  = '0;
            assign root_c = '0;
            assign rad_c  = RAD_W'(in_rad);
            assign side_c = in_side;
        end
        else
        begin : g_next
            assign v_c    = v_reg[i-1];
            assign rem_c  = rem_reg[i-1];
            assign root_c = root_reg[i-1];
            assign rad_c  = rad_reg[i-1];
            assign side_c = side_reg[i-1];
        end

        assign cur   = {rem_c, rad_c[RAD_W-1 -: 2]};
        assign trial = {2'b00, root_c, 2'b01};
        assign ge    = cur >= trial;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (adv)
                v_reg[i] <= v_c;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= ge ? REM_W'(cur - trial) : REM_W'(cur);
                root_reg[i] <= {root_c[ROOT_W-2:0], ge};
                rad_reg[i]  <= {rad_c[RAD_W-3:0], 2'b00};
                side_reg[i] <= side_c;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule

// ----- src/pgf_div.sv -----
// Pipelined restoring divider with a saturated quotient, one quotient bit per stage.
`timescale 1ns / 1ps
module pgf_div import pgf_pkg::*; #(
    parameter int NUM_W  = 104,
    parameter int DEN_W  = 66,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [FMAG_W-1:0] out_quot,
    output logic [SIDE_W-1:0] out_side
);

    localparam int HI_W = NUM_W - FMAG_W;

    // Index 0 is the overflow check; index k holds k quotient bits.
    logic              v_reg    [FMAG_W+1];
    logic              ovf_reg  [FMAG_W+1];
    logic [DEN_W-1:0]  rem_reg  [FMAG_W+1];
    logic [DEN_W-1:0]  den_reg  [FMAG_W+1];
    logic [FMAG_W-1:0] lo_reg   [FMAG_W+1];
    logic [FMAG_W-1:0] q_reg    [FMAG_W+1];
    logic [SIDE_W-1:0] side_reg [FMAG_W+1];

    logic [HI_W-1:0]   num_hi;

    assign num_hi = in_num[NUM_W-1:FMAG_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= in_valid;
    end

    // A quotient of 2^47 or more saturates; this also covers a zero divisor.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ovf_reg[0]  <= num_hi >= in_den;
            rem_reg[0]  <= DEN_W'(num_hi);
            den_reg[0]  <= in_den;
            lo_reg[0]   <= in_num[FMAG_W-1:0];
            q_reg[0]    <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 1; i <= FMAG_W; i++)
    begin : g_step
        logic [DEN_W:0] cur;
        logic           ge;

        assign cur = {rem_reg[i-1], lo_reg[i-1][FMAG_W-1]};
        assign ge  = cur >= {1'b0, den_reg[i-1]};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (adv)
                v_reg[i] <= v_reg[i-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ovf_reg[i]  <= ovf_reg[i-1];
                rem_reg[i]  <= ge ? DEN_W'(cur - {1'b0, den_reg[i-1]}) : DEN_W'(cur);
                den_reg[i]  <= den_reg[i-1];
                lo_reg[i]   <= {lo_reg[i-1][FMAG_W-2:0], 1'b0};
                q_reg[i]    <= {q_reg[i-1][FMAG_W-2:0], ge};
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign out_valid = v_reg[FMAG_W];
    assign out_quot  = ovf_reg[FMAG_W] ? '1 : q_reg[FMAG_W];
    assign out_side  = side_reg[FMAG_W];

endmodule

// ----- src/pgf_scale.sv -----
// Scales the force magnitude by each distance component through split partial products.
`timescale 1ns / 1ps
module pgf_scale import pgf_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_valid,
    input  logic [FMAG_W-1:0]      in_fmag,
    input  logic [ROOT_W-1:0]      in_dist,
    input  geo_t                   in_geo,
    output logic                   out_valid,
    output logic [2:0][PROD_W-1:0] out_prod,
    output logic [ROOT_W-1:0]      out_dist,
    output geo_t                   out_geo
);

    localparam int LO_W = SPLIT + AD_W;
    localparam int HI_W = FMAG_W - SPLIT + AD_W;

    logic                   m_valid_reg;
    logic [2:0][LO_W-1:0]   m_lo_reg;
    logic [2:0][HI_W-1:0]   m_hi_reg;
    logic [ROOT_W-1:0]      m_dist_reg;
    geo_t                   m_geo_reg;

    logic                   p_valid_reg;
    logic [2:0][PROD_W-1:0] p_prod_reg;
    logic [ROOT_W-1:0]      p_dist_reg;
    geo_t                   p_geo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            p_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_valid_reg <= in_valid;
            p_valid_reg <= m_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_lo_reg[i]   <= LO_W'(in_fmag[SPLIT-1:0]) * LO_W'(in_geo.ad[i]);
                m_hi_reg[i]   <= HI_W'(in_fmag[FMAG_W-1:SPLIT]) * HI_W'(in_geo.ad[i]);
                p_prod_reg[i] <= {m_hi_reg[i], {SPLIT{1'b0}}} + PROD_W'(m_lo_reg[i]);
            end
            m_dist_reg <= in_dist;
            m_geo_reg  <= in_geo;
            p_dist_reg <= m_dist_reg;
            p_geo_reg  <= m_geo_reg;
        end
    end

    assign out_valid = p_valid_reg;
    assign out_prod  = p_prod_reg;
    assign out_dist  = p_dist_reg;
    assign out_geo   = p_geo_reg;

endmodule

// ----- src/pairwise_gravity_force_top.sv -----
// Top level of the pairwise gravity force pipeline with collision detection.
`timescale 1ns / 1ps
// Usage: one body pair enters per beat on the s_axis channel; one result beat
// leaves on the m_axis channel for every pair, in order.
// The s_axis tdata carries the six positions, two masses and two radii; the
// tuser carries the pair kind and the enable flag. The m_axis tdata carries
// the three force components and tuser carries the collision flag.
// The gravitational constant is written through cfg_we and cfg_wdata and
// must only be changed while the pipeline holds no pair.
// The depth is set by the square root (34 stages) and two chained 48-stage
// dividers, plus front and scaling stages. One pair is accepted per cycle
// while s_axis_tready is high. When the receiver stalls, the next result
// moves into a skid register and the pipeline then holds; s_axis_tready
// drops until the skid drains, and no beat is lost or repeated.
// Reset clears all valid bits and sets the gravitational constant to zero.
module pairwise_gravity_force_top import pgf_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // self_pos_x, self_pos_y, self_pos_z, other_pos_x, other_pos_y,
    // other_pos_z, self_mass, other_mass, self_radius, other_radius
    input  logic [319:0] s_axis_tdata,
    // pair_kind, enable
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // force_x, force_y, force_z
    output logic [143:0] m_axis_tdata,
    // collided
    output logic         m_axis_tuser,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata
);

    localparam int SQ_SIDE_W = P_W + GEO_W;
    localparam int FD_SIDE_W = ROOT_W + GEO_W;

    logic [31:0] grav_const_reg;

    // The whole pipeline moves together; it only holds while the skid is full.
    logic adv;

    logic                 fr_valid;
    logic [S_W-1:0]       fr_s;
    logic [P_W-1:0]       fr_p;
    geo_t                 fr_geo;

    logic                 sq_valid;
    logic [ROOT_W-1:0]    sq_root;
    logic [SQ_SIDE_W-1:0] sq_side;
    logic [P_W-1:0]       sq_p;
    geo_t                 sq_geo;

    logic                 fd_valid;
    logic [FMAG_W-1:0]    fd_fmag;
    logic [FD_SIDE_W-1:0] fd_side;
    logic [ROOT_W-1:0]    fd_dist;
    geo_t                 fd_geo;

    logic                   sc_valid;
    logic [2:0][PROD_W-1:0] sc_prod;
    logic [ROOT_W-1:0]      sc_dist;
    geo_t                   sc_geo;

    logic [2:0]              cd_valid;
    logic [2:0][FMAG_W-1:0]  cd_quot;
    logic [2:0]              cd_side_in [3];
    logic [2:0]              cd_side_out [3];

    logic [143:0] res_data;
    logic         res_coll;
    logic         res_valid;

    logic         out_valid_reg;
    logic [143:0] out_data_reg;
    logic         out_coll_reg;
    logic         skid_valid_reg;
    logic [143:0] skid_data_reg;
    logic         skid_coll_reg;
    logic         take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grav_const_reg <= '0;
        else if (cfg_we)
            grav_const_reg <= cfg_wdata;
    end

    assign adv           = !skid_valid_reg;
    assign s_axis_tready = adv;

    pgf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (s_axis_tvalid),
        .self_pos_x   (s_axis_tdata[31:0]),
        .self_pos_y   (s_axis_tdata[63:32]),
        .self_pos_z   (s_axis_tdata[95:64]),
        .other_pos_x  (s_axis_tdata[127:96]),
        .other_pos_y  (s_axis_tdata[159:128]),
        .other_pos_z  (s_axis_tdata[191:160]),
        .self_mass    (s_axis_tdata[223:192]),
        .other_mass   (s_axis_tdata[255:224]),
        .self_radius  (s_axis_tdata[287:256]),
        .other_radius (s_axis_tdata[319:288]),
        .pair_kind    (s_axis_tuser[1:0]),
        .enable       (s_axis_tuser[2]),
        .grav_const   (grav_const_reg),
        .out_valid    (fr_valid),
        .out_s        (fr_s),
        .out_p        (fr_p),
        .out_geo      (fr_geo)
    );

    // Distance first; the mass product and geometry travel alongside.
    pgf_sqrt #(
        .SIDE_W (SQ_SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_rad    (fr_s),
        .in_side   ({fr_p, fr_geo}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    assign sq_p   = sq_side[SQ_SIDE_W-1:GEO_W];
    assign sq_geo = sq_side[GEO_W-1:0];

    // The squared length is needed again as the divisor, so it is delayed by
    // a register chain that matches the square root stages.
    logic [S_W-1:0] s_dly_reg [ROOT_W];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s_dly_reg[0] <= fr_s;
            for (int i = 1; i < ROOT_W; i++)
            begin
                s_dly_reg[i] <= s_dly_reg[i-1];
            end
        end
    end

    // Force magnitude: floor(P * 2^8 / S), saturated.
    pgf_div #(
        .NUM_W  (FNUM_W),
        .DEN_W  (S_W),
        .SIDE_W (FD_SIDE_W)
    ) u_fdiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_num    ({sq_p, 8'd0}),
        .in_den    (s_dly_reg[ROOT_W-1]),
        .in_side   ({sq_root, sq_geo}),
        .out_valid (fd_valid),
        .out_quot  (fd_fmag),
        .out_side  (fd_side)
    );

    assign fd_dist = fd_side[FD_SIDE_W-1:GEO_W];
    assign fd_geo  = fd_side[GEO_W-1:0];

    pgf_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (fd_valid),
        .in_fmag   (fd_fmag),
        .in_dist   (fd_dist),
        .in_geo    (fd_geo),
        .out_valid (sc_valid),
        .out_prod  (sc_prod),
        .out_dist  (sc_dist),
        .out_geo   (sc_geo)
    );

    // One divider per axis: floor(F * |dc| / dist), saturated.
    for (genvar c = 0; c < 3; c++)
    begin : g_axis
        assign cd_side_in[c] = {sc_geo.enable, sc_geo.collided, sc_geo.neg[c]};

        pgf_div #(
            .NUM_W  (PROD_W),
            .DEN_W  (ROOT_W),
            .SIDE_W (3)
        ) u_cdiv (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .in_valid  (sc_valid),
            .in_num    (sc_prod[c]),
            .in_den    (sc_dist),
            .in_side   (cd_side_in[c]),
            .out_valid (cd_valid[c]),
            .out_quot  (cd_quot[c]),
            .out_side  (cd_side_out[c])
        );
    end

    // Sign the magnitudes; a disabled or collided pair gives zero force.
    always_comb
    begin
        logic [OUT_W-1:0] mag;
        logic             zero;
        zero = !cd_side_out[0][2] || cd_side_out[0][1];
        for (int c = 0; c < 3; c++)
        begin
            mag = {1'b0, cd_quot[c]};
            if (zero)
                res_data[c*OUT_W +: OUT_W] = '0;
            else if (cd_side_out[c][0])
                res_data[c*OUT_W +: OUT_W] = ~mag + OUT_W'(1);
            else
                res_data[c*OUT_W +: OUT_W] = mag;
        end
        res_coll  = cd_side_out[0][1];
        res_valid = adv && (&cd_valid);
    end

    // Output register with a skid stage behind it.
    assign take = out_valid_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (take)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (take || !out_valid_reg)
        begin
            out_valid_reg <= res_valid;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (take)
            begin
                out_data_reg <= skid_data_reg;
                out_coll_reg <= skid_coll_reg;
            end
        end
        else if (take || !out_valid_reg)
        begin
            out_data_reg <= res_data;
            out_coll_reg <= res_coll;
        end
        else
        begin
            skid_data_reg <= res_data;
            skid_coll_reg <= res_coll;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_coll_reg;

endmodule

// ----- src/pgf_chk.sv -----
// Port-level checker for the pairwise gravity force top level, with its bind.
`timescale 1ns / 1ps
module pgf_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // A collided pair always reports zero force.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("collided beat with nonzero force");

    // Input back-pressure only happens while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no pending output");

    // Back-pressure persists until the receiver takes a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready && !m_axis_tready |=> !s_axis_tready)
        else $error("input released without output progress");

    // A pending output beat stays offered until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

endmodule

bind pairwise_gravity_force_top pgf_chk u_pgf_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- dv/pgf_force_checker.sv -----
// Checker that predicts and compares the force results of the pairwise gravity pipeline.
`timescale 1ns / 1ps
module pgf_force_checker import pgf_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [319:0] s_axis_tdata,
    input  logic [2:0]   s_axis_tuser,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [143:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    output int           fail_count,
    output int           pending_count
);

    localparam logic [127:0] FORCE_MAX = 128'h7FFF_FFFF_FFFF;

    typedef struct {
        logic [143:0] forces;
        logic         collided;
    } force_beat_t;

    logic [31:0]  grav_model;
    force_beat_t  pending_forces[$];

    // Computes the force on the first body exactly, with wide unsigned arithmetic.
    function automatic force_beat_t compute_force(input logic [319:0] d, input logic [2:0] u,
                                                  input logic [31:0] g);
        force_beat_t  r;
        longint       diff[3];
        logic [127:0] mag[3];
        logic [127:0] sq, contact, prod, fmag, root, cand, comp;
        logic [1:0]   kind;
        logic [47:0]  outv;
        r.forces   = '0;
        r.collided = 1'b0;
        if (!u[2])
            return r;
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = longint'($signed(d[32*(i+3) +: 32])) - longint'($signed(d[32*i +: 32]));
            mag[i]  = (diff[i] < 0) ? 128'(-diff[i]) : 128'(diff[i]);
            sq      = sq + mag[i] * mag[i];
        end
        kind = u[1:0];
        if (kind == KIND_AST_STAR)
            contact = 128'(d[287:256]) + 2 * 128'(d[319:288]);
        else if (kind == KIND_STAR_AST)
            contact = 128'(d[319:288]) + 2 * 128'(d[287:256]);
        else
            contact = 128'(d[287:256]) + 128'(d[319:288]);
        if (sq <= contact * contact)
        begin
            r.collided = 1'b1;
            return r;
        end
        prod = 128'(g) * 128'(d[223:192]) * 128'(d[255:224]);
        fmag = (prod << 8) / sq;
        if (fmag > FORCE_MAX)
            fmag = FORCE_MAX;
        root = '0;
        for (int b = 33; b >= 0; b--)
        begin
            cand = root | (128'd1 << b);
            if (cand * cand <= sq)
                root = cand;
        end
        for (int i = 0; i < 3; i++)
        begin
            comp = (fmag * mag[i]) / root;
            if (comp > FORCE_MAX)
                comp = FORCE_MAX;
            outv = (diff[i] < 0) ? -comp[47:0] : comp[47:0];
            r.forces[48*i +: 48] = outv;
        end
        return r;
    endfunction

    assign pending_count = pending_forces.size();

    always @(posedge clk or negedge rst_n)
    begin
        force_beat_t exp_beat;
        int          errs;
        if (!rst_n)
        begin
            grav_model <= '0;
            fail_count <= 0;
            pending_forces.delete();
        end
        else
        begin
            errs = 0;
            if (cfg_we)
                grav_model <= cfg_wdata;
            if (s_axis_tvalid && s_axis_tready)
                pending_forces.push_back(compute_force(s_axis_tdata, s_axis_tuser, grav_model));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_forces.size() == 0)
                begin
                    $display("%0t: unexpected result beat forces=%h collided=%b",
                             $time, m_axis_tdata, m_axis_tuser);
                    errs = errs + 1;
                end
                else
                begin
                    exp_beat = pending_forces.pop_front();
                    for (int i = 0; i < 3; i++)
                        if (exp_beat.forces[48*i +: 48] !== m_axis_tdata[48*i +: 48])
                        begin
                            $display("%0t: force component %0d expected %h actual %h",
                                     $time, i, exp_beat.forces[48*i +: 48],
                                     m_axis_tdata[48*i +: 48]);
                            errs = errs + 1;
                        end
                    if (exp_beat.collided !== m_axis_tuser)
                    begin
                        $display("%0t: collided expected %b actual %b",
                                 $time, exp_beat.collided, m_axis_tuser);
                        errs = errs + 1;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

// ----- dv/tb_pairwise_gravity_force_top.sv -----
// Testbench top that drives body pairs into the gravity force pipeline and gives the verdict.
`timescale 1ns / 1ps
module tb_pairwise_gravity_force_top;
    import pgf_pkg::*;

    localparam int DRAIN_CYCLES = 160;   // More than the pipeline latency.
    localparam int STALL_LIMIT  = 5000;  // Cycles without any accepted beat before giving up.
    localparam int HOLD_CYCLES  = 400;   // Long receiver hold-off to fill the pipeline.

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [319:0] s_axis_tdata;   // self_pos_x/y/z, other_pos_x/y/z, masses, radii
    logic [2:0]   s_axis_tuser;   // pair_kind, enable
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;   // force_x, force_y, force_z
    logic         m_axis_tuser;   // collided
    logic         cfg_we;
    logic [31:0]  cfg_wdata;

    int fail_count;
    int pending_count;
    int quiet_cycles;
    bit gaps_on;
    bit hold_request;

    pairwise_gravity_force_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    pgf_force_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The watchdog restarts its count whenever a beat moves on either channel.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // The receiver stalls in short random bursts while gaps are on. One long
    // hold-off is requested by the stimulus so that the pipeline backs up and
    // drops s_axis_tready while the sender keeps offering pairs.
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Offers one pair and waits on the clock until s_axis_tready is seen high. The valid
    // stays high into the next call unless a gap is inserted.
    task automatic send_pair(input logic [319:0] data, input logic [2:0] user);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= user;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Builds a pair from separate fields; tdata packs the first field lowest.
    task automatic send_fields(input logic [31:0] sx, sy, sz, ox, oy, oz,
                               input logic [31:0] m1, m2, r1, r2,
                               input logic [1:0] kind, input logic en);
        send_pair({r2, r1, m2, m1, oz, oy, ox, sz, sy, sx}, {en, kind});
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_grav(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // A value whose magnitude is spread over many orders of size.
    function automatic logic [31:0] spread_value();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    // Mostly pairs a modest distance apart so that forces land in range, with
    // fully random pairs and contact cases mixed in.
    task automatic send_random_pair();
        logic [31:0] self_p[3];
        logic [31:0] other_p[3];
        logic [31:0] m1, m2, r1, r2;
        logic [1:0]  kind;
        logic        en;
        int          mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
        begin
            self_p[i] = $urandom;
            if (mode < 2)
                other_p[i] = $urandom;
            else
                other_p[i] = self_p[i] + ($signed(spread_value()) >>> $urandom_range(1, 8));
        end
        m1   = spread_value();
        m2   = spread_value();
        r1   = (mode == 9) ? $urandom : spread_value() >> $urandom_range(0, 16);
        r2   = (mode == 8) ? $urandom : spread_value() >> $urandom_range(0, 16);
        kind = 2'($urandom_range(0, 3));
        en   = ($urandom_range(0, 9) != 0);
        send_fields(self_p[0], self_p[1], self_p[2], other_p[0], other_p[1], other_p[2],
                    m1, m2, r1, r2, kind, en);
    endtask

    initial
    begin
        logic [31:0] grav_settings[5];
        grav_settings = '{32'hFFFF_FFFF, 32'd0, 32'h0100_0000, 32'h0000_0001, 32'h0};
        grav_settings[4] = $urandom;
        gaps_on       = 1'b1;
        hold_request  = 1'b0;
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed pairs with G set to 2^24.
        write_grav(32'h0100_0000);
        // Disabled pair, then coincident bodies.
        send_fields(0, 0, 0, 32'h0001_0000, 0, 0, 32'h100, 32'h100, 0, 0, KIND_PLAIN, 1'b0);
        send_fields(5, 6, 7, 5, 6, 7, 32'h100, 32'h100, 0, 0, KIND_PLAIN, 1'b1);
        // Distance exactly at contact, and just beyond it, for each kind.
        send_fields(0, 0, 0, 32'h0002_0000, 0, 0, 32'h100, 32'h100,
                    32'h0001_0000, 32'h0001_0000, KIND_PLAIN, 1'b1);
        send_fields(0, 0, 0, 32'h0002_0001, 0, 0, 32'h100, 32'h100,
                    32'h0001_0000, 32'h0001_0000, KIND_PLAIN, 1'b1);
        send_fields(0, 0, 0, 0, 32'h0003_0000, 0, 32'h100, 32'h100,
                    32'h0001_0000, 32'h0001_0000, KIND_AST_STAR, 1'b1);
        send_fields(0, 0, 0, 0, 32'h0003_0001, 0, 32'h100, 32'h100,
                    32'h0001_0000, 32'h0001_0000, KIND_AST_STAR, 1'b1);
        send_fields(0, 0, 0, 0, 0, 32'hFFFD_0000, 32'h100, 32'h100,
                    32'h0001_0000, 32'h0001_0000, KIND_STAR_AST, 1'b1);
        send_fields(0, 0, 0, 0, 0, 32'hFFFC_FFFF, 32'h100, 32'h100,
                    32'h0001_0000, 32'h0001_0000, KIND_STAR_AST, 1'b1);
        send_fields(0, 0, 0, 32'h0002_0000, 0, 0, 32'h100, 32'h100,
                    32'h0001_0000, 32'h0001_0000, 2'd3, 1'b1);
        send_fields(0, 0, 0, 32'h0002_0001, 0, 0, 32'h100, 32'h100,
                    32'h0001_0000, 32'h0001_0000, 2'd3, 1'b1);
        // Widest separation, heaviest and zero masses, largest radii.
        send_fields(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, KIND_PLAIN, 1'b1);
        send_fields(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                    0, 32'hFFFF_FFFF, 0, 0, KIND_PLAIN, 1'b1);
        send_fields(0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                    32'h100, 32'h100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, KIND_AST_STAR, 1'b1);
        // Very close bodies so the magnitude saturates.
        send_fields(0, 0, 0, 1, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, KIND_PLAIN, 1'b1);
        send_fields(0, 0, 0, 32'hFFFF_FFFF, 0, 0, 32'h100, 32'h100, 0, 0, KIND_PLAIN, 1'b1);
        wait_idle();

        // Random phases through several G settings; the long receiver hold-off
        // happens in the first one and gaps stop for the last.
        for (int phase = 0; phase < 5; phase++)
        begin
            write_grav(grav_settings[phase]);
            if (phase == 0)
                hold_request = 1'b1;
            if (phase == 4)
                gaps_on = 1'b0;
            for (int n = 0; n < 150; n++)
                send_random_pair();
            wait_idle();
        end

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
src/pgf_pkg.sv
src/pgf_front.sv
src/pgf_sqrt.sv
src/pgf_div.sv
src/pgf_scale.sv
src/pairwise_gravity_force_top.sv
src/pgf_chk.sv
dv/pgf_force_checker.sv
dv/tb_pairwise_gravity_force_top.sv
